// ===== rtl/relative_strength_index_assert.svh =====
// ----------------------------------------------------------------------------
// Relative strength index assertion macros
// Shared property wrappers for the checker, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_STRENGTH_INDEX_ASSERT_SVH
`define RELATIVE_STRENGTH_INDEX_ASSERT_SVH

// Property that is switched off while reset is held.
`define RSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property that is also checked across reset.
`define RSI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Relative strength index package
// Field widths, transaction types, sequencer codes and defaults.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int PERIOD_W        = 9;
    localparam int PRICE_W         = 32;
    localparam int ACC_W           = 56;
    localparam int AVG_W           = 48;
    localparam int RSI_W           = 23;
    localparam int NUMER_W         = 64;
    localparam int RSI_SCALE       = 100;
    localparam int RSI_SCALE_W     = 7;
    localparam int STEP_W          = 7;
    localparam int DEF_MAX_PERIOD  = 256;
    localparam int DEF_FRAC_BITS   = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd14;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               new_series;
    } in_item_t;

    typedef struct packed {
        logic [RSI_W-1:0] rsi_value;
        logic [AVG_W-1:0] avg_gain;
        logic [AVG_W-1:0] avg_loss;
    } out_item_t;

    // Command from the sequencer to the divider.
    typedef struct packed {
        logic              load;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_RESULT = 5'b10000
    } rsi_state_t;

    typedef enum logic [2:0] {
        PH_GAIN  = 3'b001,
        PH_LOSS  = 3'b010,
        PH_RATIO = 3'b100
    } rsi_phase_t;

endpackage

// ===== rtl/rsi_div.sv =====
// ----------------------------------------------------------------------------
// Relative strength index divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module rsi_div #(
    parameter int NUM_W = 79,
    parameter int DEN_W = 57
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rsi_pkg::div_ctl_t    ctl,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic                 done,
    output logic [NUM_W-1:0]     quot
);

    logic [NUM_W-1:0]          shift_reg, shift_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [rsi_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                      done_reg, done_next;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] diff;
    logic           ge;

    // The dividend shifts out at the top while quotient bits enter at the
    // bottom, so after the last step the low bits hold the quotient.
    assign rem_shift = {rem_reg, shift_reg[NUM_W-1]};
    assign ge        = rem_shift >= (DEN_W+1)'(den_reg);
    assign diff      = rem_shift - (DEN_W+1)'(den_reg);

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (ctl.load) begin
            shift_next = num;
            rem_next   = '0;
            den_next   = den;
            cnt_next   = ctl.steps;
        end else if (cnt_reg != '0) begin
            shift_next = {shift_reg[NUM_W-2:0], ge};
            rem_next   = ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == rsi_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
    end

    assign done = done_reg;
    assign quot = shift_reg;

endmodule

// ===== rtl/relative_strength_index.sv =====
// ----------------------------------------------------------------------------
// Relative strength index
// Wilder RSI over a price stream, fixed point, one shared serial divider.
// ----------------------------------------------------------------------------
// Each input transaction carries one price in integer ticks. The first price
// after reset, or any price flagged new_series, only restarts the series and
// produces no result; it is taken and the block stays ready. While the first
// period changes are gathered, each price is also taken with no result. The
// change that completes the period seeds both averages, and every change after
// it smooths them with avg = (avg*(period-1) + change)/period; these transactions
// each produce one result carrying the RSI and both averages, all with
// FRAC_BITS fraction bits. Such a transaction occupies the block for a gain
// average division, a loss average division and a ratio division, the ratio
// being skipped when either average is zero. All three run in turn on the
// single restoring divider, which retires one quotient bit per cycle; s_ready
// is low for that whole time. A finished result sits in an output register,
// so the next transaction is taken while it waits for m_ready. The period
// register is written through cfg_wr_en and cfg_wr_data; 0 acts as 1 and
// values above MAX_PERIOD act as MAX_PERIOD.
// ----------------------------------------------------------------------------
module relative_strength_index #(
    parameter int MAX_PERIOD = rsi_pkg::DEF_MAX_PERIOD,
    parameter int FRAC_BITS  = rsi_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rsi_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rsi_pkg::out_item_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_wr_data
);

    // Period and change counter width, enough to hold MAX_PERIOD itself.
    localparam int P_W     = $clog2(MAX_PERIOD + 1);
    // The ratio numerator is G * 100 << FRAC_BITS.
    localparam int RATIO_W = rsi_pkg::ACC_W + rsi_pkg::RSI_SCALE_W + FRAC_BITS;
    localparam int DEN_W   = rsi_pkg::ACC_W + 1;
    localparam int NUM_PAD = RATIO_W - rsi_pkg::NUMER_W;
    localparam logic [RATIO_W-1:0] RSI_FULL = RATIO_W'(rsi_pkg::RSI_SCALE) << FRAC_BITS;

    // Control state.
    rsi_pkg::rsi_state_t           state_reg, state_next;
    rsi_pkg::rsi_phase_t           phase_reg, phase_next;
    logic [rsi_pkg::PERIOD_W-1:0]  period_reg, period_next;
    logic                          has_prior_reg, has_prior_next;
    logic                          seeded_reg, seeded_next;
    logic [P_W-1:0]                changes_seen_reg, changes_seen_next;
    logic                          m_valid_reg, m_valid_next;

    // Datapath state.
    logic [rsi_pkg::PRICE_W-1:0]   prior_price_reg, prior_price_next;
    logic [rsi_pkg::ACC_W-1:0]     gain_accum_reg, gain_accum_next;
    logic [rsi_pkg::ACC_W-1:0]     loss_accum_reg, loss_accum_next;
    logic [rsi_pkg::PRICE_W-1:0]   change_g_reg, change_g_next;
    logic [rsi_pkg::PRICE_W-1:0]   change_l_reg, change_l_next;
    logic                          seed_mode_reg, seed_mode_next;
    logic [P_W-1:0]                p_reg, p_next;
    logic [RATIO_W-1:0]            num_reg, num_next;
    logic [DEN_W-1:0]              den_reg, den_next;
    logic [rsi_pkg::STEP_W-1:0]    steps_reg, steps_next;
    logic [rsi_pkg::RSI_W-1:0]     rsi_reg, rsi_next;
    rsi_pkg::out_item_t            out_reg, out_next;

    // Combinational helpers.
    logic                          accept;
    logic [P_W-1:0]                p_clamp;
    logic [P_W-1:0]                pm1;
    logic                          rising;
    logic [rsi_pkg::PRICE_W-1:0]   gain_in;
    logic [rsi_pkg::PRICE_W-1:0]   loss_in;
    logic [rsi_pkg::ACC_W-1:0]     gain_sum;
    logic [rsi_pkg::ACC_W-1:0]     loss_sum;
    logic [P_W-1:0]                cnt_inc;
    logic [rsi_pkg::ACC_W-1:0]     acc_sel;
    logic [rsi_pkg::PRICE_W-1:0]   chg_sel;
    logic [rsi_pkg::NUMER_W-1:0]   seed_num;
    logic [rsi_pkg::NUMER_W-1:0]   smooth_num;
    logic [rsi_pkg::NUMER_W-1:0]   avg_num;
    logic [RATIO_W-1:0]            ratio_num;
    logic [DEN_W-1:0]              ratio_den;

    rsi_pkg::div_ctl_t             div_ctl;
    logic                          div_done;
    logic [RATIO_W-1:0]            div_quot;

    assign accept = s_valid && s_ready;

    // Out-of-range periods are folded into 1 .. MAX_PERIOD.
    always_comb begin
        if (period_reg == '0) begin
            p_clamp = P_W'(1);
        end else if (32'(period_reg) > 32'(MAX_PERIOD)) begin
            p_clamp = P_W'(MAX_PERIOD);
        end else begin
            p_clamp = P_W'(period_reg);
        end
    end

    assign rising   = s_data.price > prior_price_reg;
    assign gain_in  = rising ? (s_data.price - prior_price_reg) : '0;
    assign loss_in  = rising ? '0 : (prior_price_reg - s_data.price);
    assign gain_sum = gain_accum_reg + rsi_pkg::ACC_W'(gain_in);
    assign loss_sum = loss_accum_reg + rsi_pkg::ACC_W'(loss_in);
    assign cnt_inc  = changes_seen_reg + P_W'(1);

    // Numerator of the average update for the phase in progress. Both forms
    // wrap at 64 bits, matching the width of the averaging arithmetic.
    assign pm1        = p_reg - P_W'(1);
    assign acc_sel    = (phase_reg == rsi_pkg::PH_GAIN) ? gain_accum_reg : loss_accum_reg;
    assign chg_sel    = (phase_reg == rsi_pkg::PH_GAIN) ? change_g_reg : change_l_reg;
    assign seed_num   = rsi_pkg::NUMER_W'(acc_sel) << FRAC_BITS;
    assign smooth_num = rsi_pkg::NUMER_W'(rsi_pkg::NUMER_W'(acc_sel) * rsi_pkg::NUMER_W'(pm1))
                      + (rsi_pkg::NUMER_W'(chg_sel) << FRAC_BITS);
    assign avg_num    = seed_mode_reg ? seed_num : smooth_num;

    // RSI = G * (100 << FRAC_BITS) / (G + L).
    assign ratio_num = (RATIO_W'(gain_accum_reg) * RATIO_W'(rsi_pkg::RSI_SCALE)) << FRAC_BITS;
    assign ratio_den = DEN_W'(gain_accum_reg) + DEN_W'(loss_accum_reg);

    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        period_next       = period_reg;
        has_prior_next    = has_prior_reg;
        seeded_next       = seeded_reg;
        changes_seen_next = changes_seen_reg;
        m_valid_next      = m_valid_reg;
        prior_price_next  = prior_price_reg;
        gain_accum_next   = gain_accum_reg;
        loss_accum_next   = loss_accum_reg;
        change_g_next     = change_g_reg;
        change_l_next     = change_l_reg;
        seed_mode_next    = seed_mode_reg;
        p_next            = p_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        steps_next        = steps_reg;
        rsi_next          = rsi_reg;
        out_next          = out_reg;
        div_ctl.load      = 1'b0;
        div_ctl.steps     = steps_reg;

        if (cfg_wr_en) begin
            period_next = cfg_wr_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rsi_pkg::ST_IDLE: begin
                if (accept) begin
                    prior_price_next = s_data.price;
                    if (s_data.new_series || !has_prior_reg) begin
                        // Start of a series: only the price is kept.
                        has_prior_next    = 1'b1;
                        seeded_next       = 1'b0;
                        changes_seen_next = '0;
                        gain_accum_next   = '0;
                        loss_accum_next   = '0;
                    end else if (!seeded_reg) begin
                        gain_accum_next = gain_sum;
                        loss_accum_next = loss_sum;
                        if (cnt_inc >= p_clamp) begin
                            seeded_next       = 1'b1;
                            changes_seen_next = '0;
                            seed_mode_next    = 1'b1;
                            p_next            = p_clamp;
                            phase_next        = rsi_pkg::PH_GAIN;
                            state_next        = rsi_pkg::ST_MUL;
                        end else begin
                            changes_seen_next = cnt_inc;
                        end
                    end else begin
                        change_g_next  = gain_in;
                        change_l_next  = loss_in;
                        seed_mode_next = 1'b0;
                        p_next         = p_clamp;
                        phase_next     = rsi_pkg::PH_GAIN;
                        state_next     = rsi_pkg::ST_MUL;
                    end
                end
            end

            rsi_pkg::ST_MUL: begin
                if (phase_reg == rsi_pkg::PH_RATIO) begin
                    if (loss_accum_reg == '0) begin
                        rsi_next   = RSI_FULL[rsi_pkg::RSI_W-1:0];
                        state_next = rsi_pkg::ST_RESULT;
                    end else if (gain_accum_reg == '0) begin
                        rsi_next   = '0;
                        state_next = rsi_pkg::ST_RESULT;
                    end else begin
                        num_next   = ratio_num;
                        den_next   = ratio_den;
                        steps_next = rsi_pkg::STEP_W'(RATIO_W);
                        state_next = rsi_pkg::ST_LOAD;
                    end
                end else begin
                    // The 64-bit dividend is left-aligned so that its quotient
                    // lands in the low bits after 64 steps.
                    num_next   = {avg_num, {NUM_PAD{1'b0}}};
                    den_next   = DEN_W'(p_reg);
                    steps_next = rsi_pkg::STEP_W'(rsi_pkg::NUMER_W);
                    state_next = rsi_pkg::ST_LOAD;
                end
            end

            rsi_pkg::ST_LOAD: begin
                div_ctl.load = 1'b1;
                state_next   = rsi_pkg::ST_DIV;
            end

            rsi_pkg::ST_DIV: begin
                if (div_done) begin
                    unique case (phase_reg)
                        rsi_pkg::PH_GAIN: begin
                            gain_accum_next = div_quot[rsi_pkg::ACC_W-1:0];
                            phase_next      = rsi_pkg::PH_LOSS;
                            state_next      = rsi_pkg::ST_MUL;
                        end
                        rsi_pkg::PH_LOSS: begin
                            loss_accum_next = div_quot[rsi_pkg::ACC_W-1:0];
                            phase_next      = rsi_pkg::PH_RATIO;
                            state_next      = rsi_pkg::ST_MUL;
                        end
                        rsi_pkg::PH_RATIO: begin
                            rsi_next   = div_quot[rsi_pkg::RSI_W-1:0];
                            state_next = rsi_pkg::ST_RESULT;
                        end
                        default: begin
                            state_next = rsi_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            rsi_pkg::ST_RESULT: begin
                // Wait here only while an older result is still unclaimed.
                if (!m_valid_reg || m_ready) begin
                    out_next.rsi_value = rsi_reg;
                    out_next.avg_gain  = gain_accum_reg[rsi_pkg::AVG_W-1:0];
                    out_next.avg_loss  = loss_accum_reg[rsi_pkg::AVG_W-1:0];
                    m_valid_next       = 1'b1;
                    state_next         = rsi_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= rsi_pkg::ST_IDLE;
            phase_reg        <= rsi_pkg::PH_GAIN;
            period_reg       <= rsi_pkg::PERIOD_RESET;
            has_prior_reg    <= 1'b0;
            seeded_reg       <= 1'b0;
            changes_seen_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            period_reg       <= period_next;
            has_prior_reg    <= has_prior_next;
            seeded_reg       <= seeded_next;
            changes_seen_reg <= changes_seen_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prior_price_reg <= prior_price_next;
        gain_accum_reg  <= gain_accum_next;
        loss_accum_reg  <= loss_accum_next;
        change_g_reg    <= change_g_next;
        change_l_reg    <= change_l_next;
        seed_mode_reg   <= seed_mode_next;
        p_reg           <= p_next;
        num_reg         <= num_next;
        den_reg         <= den_next;
        steps_reg       <= steps_next;
        rsi_reg         <= rsi_next;
        out_reg         <= out_next;
    end

    rsi_div #(
        .NUM_W (RATIO_W),
        .DEN_W (DEN_W)
    ) u_rsi_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_ready = (state_reg == rsi_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// Relative strength index checker
// Port-level properties of the block, attached to every instance by bind.
// ----------------------------------------------------------------------------
`include "relative_strength_index_assert.svh"

module rsi_checker #(
    parameter int FRAC_BITS = rsi_pkg::DEF_FRAC_BITS
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input rsi_pkg::in_item_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input rsi_pkg::out_item_t  m_data
);

    localparam logic [63:0] RSI_LIMIT = 64'(rsi_pkg::RSI_SCALE) << FRAC_BITS;

    // Reset empties the output register.
    `RSI_ASSERT_ALWAYS(a_reset_clears_result, !$past(aresetn) |-> !m_valid, "result valid after reset")

    // A transaction never yields its result in the very next cycle.
    `RSI_ASSERT(a_no_instant_result, (s_valid && s_ready) |=> !$rose(m_valid), "result too early")

    // A new result is loaded only while the input side is busy.
    `RSI_ASSERT(a_result_while_busy, $rose(m_valid) |-> !$past(s_ready), "result loaded while idle")

    // A stalled result holds its payload.
    `RSI_ASSERT(a_result_holds, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "result changed while stalled")

    // The ratio never exceeds 100.
    `RSI_ASSERT(a_rsi_range, m_valid |-> (64'(m_data.rsi_value) <= RSI_LIMIT), "rsi out of range")

endmodule

bind relative_strength_index rsi_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_rsi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/relative_strength_index_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative strength index testbench
// Drives price transactions through the block with random idle cycles on
// both sides; checks each result against a typed row or a Wilder RSI predictor.
// ----------------------------------------------------------------------------
module relative_strength_index_test;

    // Clocking and run shape.
    localparam int CLK_HALF     = 6;
    // The block takes less than this to finish a result transaction, so this
    // covers any transaction that is still in flight after the last result.
    localparam int DRAIN_CYCLES = 400;
    localparam int GAP_MAX      = 19;
    localparam int PHASES       = 9;

    // Arithmetic constants, taken from the package defaults.
    localparam int FRAC  = rsi_pkg::DEF_FRAC_BITS;
    localparam int MAX_P = rsi_pkg::DEF_MAX_PERIOD;
    localparam logic [63:0] RSI_FULL = 64'(rsi_pkg::RSI_SCALE) << FRAC;
    localparam logic [rsi_pkg::RSI_W-1:0] RSI_TOP = RSI_FULL[rsi_pkg::RSI_W-1:0];
    localparam rsi_pkg::out_item_t NO_RESULT = '0;

    // A row of the directed table either writes the period register or
    // sends one price. Where the expected result is obvious it is typed in
    // the row and checked as written, otherwise the predictor supplies it.
    typedef enum logic {
        ROW_PRICE,
        ROW_PERIOD
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [31:0]        value;
        logic               new_series;
        logic               typed;
        rsi_pkg::out_item_t want;
    } table_row_t;

    localparam int DIRECTED_ROWS = 29;

    // The opening rows run at the reset period of 14: a first price, then
    // fourteen rises of one tick, which seed a gain average of exactly one
    // tick and no loss. The period then drops to one so that every change
    // yields a result, and the price swings across its full range to hit
    // the zero-gain and zero-loss cases, including both averages at zero.
    // A period of zero must act as one and a period above the maximum must
    // act as the maximum. The last rows restart the series twice, once
    // while a long seeding is under way.
    table_row_t directed [DIRECTED_ROWS] = '{
        '{ROW_PRICE,  32'd0,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd1,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd2,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd3,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd4,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd5,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd6,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd7,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd8,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd9,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd10,         1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd11,         1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd12,         1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd13,         1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd14,         1'b0, 1'b1, '{RSI_TOP, 48'd65536, 48'd0}},
        '{ROW_PERIOD, 32'd1,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'hFFFF_FFFF,  1'b1, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd0,          1'b0, 1'b1, '{23'd0, 48'd0, 48'hFFFF_FFFF_0000}},
        '{ROW_PRICE,  32'hFFFF_FFFF,  1'b0, 1'b1, '{RSI_TOP, 48'hFFFF_FFFF_0000, 48'd0}},
        '{ROW_PRICE,  32'hFFFF_FFFF,  1'b0, 1'b1, '{RSI_TOP, 48'd0, 48'd0}},
        '{ROW_PERIOD, 32'd0,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'h8000_0000,  1'b0, 1'b1, '{23'd0, 48'd0, 48'h7FFF_FFFF_0000}},
        '{ROW_PERIOD, 32'd257,        1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd1000,       1'b1, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd900,        1'b0, 1'b0, NO_RESULT},
        '{ROW_PERIOD, 32'd2,          1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd500,        1'b1, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd800,        1'b0, 1'b0, NO_RESULT},
        '{ROW_PRICE,  32'd700,        1'b0, 1'b0, NO_RESULT}
    };

    // Block ports.
    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    rsi_pkg::in_item_t           s_data;
    logic                        m_valid;
    logic                        m_ready;
    rsi_pkg::out_item_t          m_data;
    logic                        cfg_wr_en;
    logic [rsi_pkg::PERIOD_W-1:0] cfg_wr_data;

    // Predictor state: the last price, the number of changes gathered while
    // seeding, and the two accumulators that hold whole-tick sums during
    // seeding and fixed-point averages afterwards.
    logic [31:0]                 last_price;
    int unsigned                 seed_count;
    logic [55:0]                 gain_avg;
    logic [55:0]                 loss_avg;
    bit                          primed;
    bit                          smoothing;
    logic [rsi_pkg::PERIOD_W-1:0] period_reg;

    // Results that are owed by the block, oldest first.
    rsi_pkg::out_item_t          pending_rsi[$];
    int                          mismatches = 0;
    bit                          send_quiet = 1'b0;

    relative_strength_index #(
        .MAX_PERIOD (MAX_P),
        .FRAC_BITS  (FRAC)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Works out what one accepted price transaction should produce and
    // advances the predictor state. Returns 1 when a result is due.
    function automatic bit predict_rsi(input rsi_pkg::in_item_t txn,
                                       output rsi_pkg::out_item_t res);
        logic [63:0]  p;
        logic [63:0]  gain;
        logic [63:0]  loss;
        logic [63:0]  ratio;
        logic [127:0] scaled;
        res = '0;
        // The period is clamped on every transaction, not when written.
        p = 64'(period_reg);
        if (p == 0) begin
            p = 64'd1;
        end else if (p > MAX_P) begin
            p = 64'(MAX_P);
        end
        // A first price, or a flagged one, only restarts the series.
        if (txn.new_series || !primed) begin
            last_price = txn.price;
            primed     = 1'b1;
            seed_count = 0;
            gain_avg   = '0;
            loss_avg   = '0;
            smoothing  = 1'b0;
            return 1'b0;
        end
        gain = '0;
        loss = '0;
        if (txn.price > last_price) begin
            gain = 64'(txn.price - last_price);
        end else begin
            loss = 64'(last_price - txn.price);
        end
        last_price = txn.price;
        // The intermediate products are kept at 64 bits so that they wrap
        // exactly where the block's datapath is defined to wrap.
        if (!smoothing) begin
            gain_avg = gain_avg + 56'(gain);
            loss_avg = loss_avg + 56'(loss);
            seed_count++;
            // Seeding ends as soon as the count reaches the current period,
            // even if the period was lowered part way through.
            if (64'(seed_count) < p) begin
                return 1'b0;
            end
            gain_avg   = 56'(({8'd0, gain_avg} << FRAC) / p);
            loss_avg   = 56'(({8'd0, loss_avg} << FRAC) / p);
            smoothing  = 1'b1;
            seed_count = 0;
        end else begin
            gain_avg = 56'(({8'd0, gain_avg} * (p - 64'd1) + (gain << FRAC)) / p);
            loss_avg = 56'(({8'd0, loss_avg} * (p - 64'd1) + (loss << FRAC)) / p);
        end
        // A zero loss average reads as full strength even when the gain
        // average is zero too; a zero gain average alone reads as zero.
        if (loss_avg == 0) begin
            ratio = RSI_FULL;
        end else if (gain_avg == 0) begin
            ratio = '0;
        end else begin
            scaled = (128'(gain_avg) * 128'(RSI_FULL)) /
                     (128'(gain_avg) + 128'(loss_avg));
            ratio  = scaled[63:0];
        end
        res.rsi_value = ratio[rsi_pkg::RSI_W-1:0];
        res.avg_gain  = gain_avg[rsi_pkg::AVG_W-1:0];
        res.avg_loss  = loss_avg[rsi_pkg::AVG_W-1:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Presents one price transaction after a random idle stretch and waits
    // for the handshake. Valid is only lowered when an idle stretch follows,
    // so back-to-back transactions keep it high across the boundary. When
    // the row carries a typed result, that result is owed instead of the
    // predicted one, though the predictor still advances.
    task automatic send_price(input logic [31:0] price, input logic new_series,
                              input bit typed, input rsi_pkg::out_item_t want);
        int                 gap;
        rsi_pkg::in_item_t  txn;
        rsi_pkg::out_item_t res;
        txn.price      = price;
        txn.new_series = new_series;
        if ($urandom_range(0, 31) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= txn;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (predict_rsi(txn, res)) begin
            pending_rsi = {pending_rsi, (typed ? want : res)};
        end
    endtask

    // Writes the period register once the block has gone quiet: every owed
    // result has come back and a transaction with no result has had time
    // to finish.
    task automatic set_period(input logic [rsi_pkg::PERIOD_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_rsi.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        period_reg  = value;
    endtask

    // Result side: a random stall before each transaction, with stretches
    // where ready stays high. Each accepted result is checked field by field
    // against the oldest owed result.
    initial begin
        int                 stall;
        bit                 quiet;
        rsi_pkg::out_item_t want;
        quiet = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                quiet = !quiet;
            end
            stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_rsi.size() == 0) begin
                report_mismatch("result with nothing owed", m_data.rsi_value, '0);
            end else begin
                want = pending_rsi.pop_front();
                if (m_data.rsi_value !== want.rsi_value) begin
                    report_mismatch("rsi_value", m_data.rsi_value, want.rsi_value);
                end
                if (m_data.avg_gain !== want.avg_gain) begin
                    report_mismatch("avg_gain", m_data.avg_gain, want.avg_gain);
                end
                if (m_data.avg_loss !== want.avg_loss) begin
                    report_mismatch("avg_loss", m_data.avg_loss, want.avg_loss);
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases. Each phase
    // sets a new period and sends a price walk whose trend changes now and
    // then, so that the RSI visits both ends of its range as well as the
    // middle. A few transactions jump to random or extreme prices, and a
    // few restart the series.
    initial begin
        logic [rsi_pkg::PERIOD_W-1:0] phase_period;
        int                           phase_items;
        int                           restart_pct;
        int                           trend;
        int unsigned                  roll;
        int unsigned                  delta;
        logic [31:0]                  walk;
        logic                         new_series;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        last_price  = '0;
        seed_count  = 0;
        gain_avg    = '0;
        loss_avg    = '0;
        primed      = 1'b0;
        smoothing   = 1'b0;
        period_reg  = rsi_pkg::PERIOD_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_PERIOD) begin
                set_period(directed[i].value[rsi_pkg::PERIOD_W-1:0]);
            end else begin
                send_price(directed[i].value, directed[i].new_series,
                           directed[i].typed, directed[i].want);
            end
        end

        walk  = 32'd100_000;
        trend = 3;
        for (int ph = 0; ph < PHASES; ph++) begin
            unique case (ph)
                0: phase_period = 9'(MAX_P);
                1: phase_period = 9'd1;
                2: phase_period = 9'd0;
                3: phase_period = 9'd2;
                4: phase_period = 9'd3;
                5: phase_period = rsi_pkg::PERIOD_RESET;
                default: phase_period = 9'($urandom_range(4, 24));
            endcase
            // The longest period needs an unbroken run of changes to seed,
            // so that phase never restarts the series after its first price.
            phase_items = (ph == 0) ? 290 : 58;
            restart_pct = (ph == 0) ? 0 : 3;
            set_period(phase_period);
            for (int i = 0; i < phase_items; i++) begin
                new_series = 1'b0;
                if ($urandom_range(0, 39) == 0) begin
                    trend = $urandom_range(0, 3);
                end
                roll = $urandom_range(0, 99);
                if (i == 0) begin
                    // A phase may open mid-series, carrying on with the new
                    // period, or with a fresh series.
                    new_series = (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1));
                    walk       = $urandom;
                end else if (roll < restart_pct) begin
                    new_series = 1'b1;
                    walk       = $urandom;
                end else if (roll < 6) begin
                    walk = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                end else if (roll < 12) begin
                    walk = $urandom;
                end else begin
                    delta = $urandom_range(0, 32'd1 << $urandom_range(0, 20));
                    if (trend == 2 && $urandom_range(0, 3) != 0) begin
                        delta = 0;
                    end
                    // Trend 0 mostly rises, trend 1 mostly falls, the rest
                    // go either way with equal odds.
                    if ($urandom_range(0, 9) < ((trend == 0) ? 9 : (trend == 1) ? 1 : 5)) begin
                        walk = walk + delta;
                    end else begin
                        walk = walk - delta;
                    end
                end
                send_price(walk, new_series, 1'b0, NO_RESULT);
            end
        end

        // Let every owed result come back, then watch for strays.
        s_valid <= 1'b0;
        while (pending_rsi.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run of about 2.5 ms.
    initial begin
        #(30_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== relative_strength_index.f =====
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_div.sv
rtl/relative_strength_index.sv
rtl/rsi_checker.sv
dv/relative_strength_index_test.sv
